[hw/rtl/qdec_pkg.sv]
// shared types, constants and the x4 step table for the dual quadrature decoder
// no dependencies
package qdec_pkg;

    localparam int NUM_LANES         = 2;
    localparam int LEVEL_W           = 2;
    localparam int OUT_W             = 32;
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int CFG_INDEX_W       = 8;
    localparam int CFG_DATA_W        = 32;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } step_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INVERT_A = 8'd0,
        REG_INVERT_B = 8'd1
    } cfg_reg_t;

    // indexed by {previous levels, current levels}
    localparam step_t STEP_TABLE [16] = '{
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE
    };

    typedef struct packed {
        logic signed [OUT_W-1:0] position_a;
        logic signed [OUT_W-1:0] position_b;
        logic [OUT_W-1:0]        steps_a;
        logic [OUT_W-1:0]        steps_b;
        logic [OUT_W-1:0]        invalid_a;
        logic [OUT_W-1:0]        invalid_b;
        logic [OUT_W-1:0]        toggles_a_phase_a;
        logic [OUT_W-1:0]        toggles_a_phase_b;
        logic [OUT_W-1:0]        toggles_b_phase_a;
        logic [OUT_W-1:0]        toggles_b_phase_b;
    } result_t;

    function automatic step_t decode_step(input logic [LEVEL_W-1:0] prev,
                                          input logic [LEVEL_W-1:0] cur);
        return STEP_TABLE[{prev, cur}];
    endfunction

endpackage

[hw/rtl/dual_quadrature_decoder.sv]
// Dual x4 quadrature decoder. Every accepted word is one sample of both encoders
// and is decoded by two identical lanes, one per encoder; a word can be accepted
// on every cycle while s_ready is high. The result word on the m_ channel is a
// registered word that carries the counts after the update. A two-entry output
// buffer keeps the input side open for one more word while the output stalls, so
// s_ready drops only once both entries hold results. A restart word (cmd high) zeroes
// every counter and takes its levels as the previous levels. Configuration writes are
// always taken (cfg_ready is tied high); indexes past invert_b are ignored.
// depends on qdec_pkg, qdec_lane, qdec_merge
module dual_quadrature_decoder import qdec_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_cmd,
    input  logic [LEVEL_W-1:0]      s_levels_a,
    input  logic [LEVEL_W-1:0]      s_levels_b,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_position_a,
    output logic signed [OUT_W-1:0] m_position_b,
    output logic [OUT_W-1:0]        m_steps_a,
    output logic [OUT_W-1:0]        m_steps_b,
    output logic [OUT_W-1:0]        m_invalid_a,
    output logic [OUT_W-1:0]        m_invalid_b,
    output logic [OUT_W-1:0]        m_toggles_a_phase_a,
    output logic [OUT_W-1:0]        m_toggles_a_phase_b,
    output logic [OUT_W-1:0]        m_toggles_b_phase_a,
    output logic [OUT_W-1:0]        m_toggles_b_phase_b
);

    logic invert_a_reg;
    logic invert_b_reg;
    logic s_fire;

    logic [NUM_LANES-1:0]                    lane_invert;
    logic [NUM_LANES-1:0][LEVEL_W-1:0]       lane_levels;
    logic [NUM_LANES-1:0][COUNT_WIDTH-1:0]   pos_cnt;
    logic [NUM_LANES-1:0][COUNT_WIDTH-1:0]   step_cnt;
    logic [NUM_LANES-1:0][COUNT_WIDTH-1:0]   bad_cnt;
    logic [2*NUM_LANES-1:0][COUNT_WIDTH-1:0] tog_cnt;
    result_t                                 m_result;

    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_a_reg <= 1'b0;
            invert_b_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_INVERT_A: invert_a_reg <= cfg_wdata[0];
                REG_INVERT_B: invert_b_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign lane_invert = {invert_b_reg, invert_a_reg};
    assign lane_levels = {s_levels_b, s_levels_a};

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        qdec_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .item_fire (s_fire),
            .cmd       (s_cmd),
            .levels    (lane_levels[i]),
            .invert    (lane_invert[i]),
            .pos_next  (pos_cnt[i]),
            .step_next (step_cnt[i]),
            .bad_next  (bad_cnt[i]),
            .tog_next  (tog_cnt[2*i+1:2*i])
        );
    end

    qdec_merge #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .pos_cnt  (pos_cnt),
        .step_cnt (step_cnt),
        .bad_cnt  (bad_cnt),
        .tog_cnt  (tog_cnt),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_position_a        = m_result.position_a;
    assign m_position_b        = m_result.position_b;
    assign m_steps_a           = m_result.steps_a;
    assign m_steps_b           = m_result.steps_b;
    assign m_invalid_a         = m_result.invalid_a;
    assign m_invalid_b         = m_result.invalid_b;
    assign m_toggles_a_phase_a = m_result.toggles_a_phase_a;
    assign m_toggles_a_phase_b = m_result.toggles_a_phase_b;
    assign m_toggles_b_phase_a = m_result.toggles_b_phase_a;
    assign m_toggles_b_phase_b = m_result.toggles_b_phase_b;

`ifndef SYNTHESIS
    // a full skid entry implies the main output entry is full too
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // an unstalled restart shows zero positions, steps_a, invalid_b, toggles_b_phase_b
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_cmd && (!m_valid || m_ready)) |=>
            (m_valid && m_position_a == '0 && m_position_b == '0 &&
             m_steps_a == '0 && m_invalid_b == '0 && m_toggles_b_phase_b == '0))
        else $error("restart did not clear the counts");

    // a sample with unchanged a levels keeps steps_a, invalid_a and toggles_a_phase_a
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_cmd && (!m_valid || m_ready) && !$past(s_fire && s_cmd) &&
         s_levels_a == $past(s_levels_a) && $past(s_fire) &&
         $past(!m_valid || m_ready)) |=>
            (m_steps_a == $past(m_steps_a) && m_invalid_a == $past(m_invalid_a) &&
             m_toggles_a_phase_a == $past(m_toggles_a_phase_a)))
        else $error("idle encoder a changed its counts");
`endif

endmodule

[hw/rtl/qdec_lane.sv]
// one encoder lane: previous levels, position, step, invalid and toggle counters
// depends on qdec_pkg
module qdec_lane import qdec_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        item_fire,
    input  logic                        cmd,
    input  logic [LEVEL_W-1:0]          levels,
    input  logic                        invert,
    output logic [COUNT_WIDTH-1:0]      pos_next,
    output logic [COUNT_WIDTH-1:0]      step_next,
    output logic [COUNT_WIDTH-1:0]      bad_next,
    output logic [1:0][COUNT_WIDTH-1:0] tog_next
);

    localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

    logic [LEVEL_W-1:0]          prev_reg;
    logic [COUNT_WIDTH-1:0]      pos_reg;
    logic [COUNT_WIDTH-1:0]      step_reg;
    logic [COUNT_WIDTH-1:0]      bad_reg;
    logic [1:0][COUNT_WIDTH-1:0] tog_reg;

    step_t              step;
    logic [LEVEL_W-1:0] diff;
    logic               up;

    assign step = decode_step(prev_reg, levels);
    assign diff = prev_reg ^ levels;
    assign up   = (step == STEP_UP) ^ invert;

    always_comb begin
        pos_next  = pos_reg;
        step_next = step_reg;
        bad_next  = bad_reg;
        tog_next  = tog_reg;
        if (cmd) begin
            pos_next  = '0;
            step_next = '0;
            bad_next  = '0;
            tog_next  = '0;
        end else begin
            if (step == STEP_NONE) begin
                if (diff != '0) begin
                    bad_next = bad_reg + ONE;
                end
            end else begin
                pos_next  = up ? pos_reg + ONE : pos_reg - ONE;
                step_next = step_reg + ONE;
            end
            // slot 0 is phase A (level bit 1), slot 1 is phase B (level bit 0)
            if (diff[1]) begin
                tog_next[0] = tog_reg[0] + ONE;
            end
            if (diff[0]) begin
                tog_next[1] = tog_reg[1] + ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            pos_reg  <= '0;
            step_reg <= '0;
            bad_reg  <= '0;
            tog_reg  <= '0;
        end else if (item_fire) begin
            prev_reg <= levels;
            pos_reg  <= pos_next;
            step_reg <= step_next;
            bad_reg  <= bad_next;
            tog_reg  <= tog_next;
        end
    end

endmodule

[hw/rtl/qdec_merge.sv]
// merges the lane counts into one result word and buffers it in a two-entry skid
// depends on qdec_pkg
module qdec_merge import qdec_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [NUM_LANES-1:0][COUNT_WIDTH-1:0]   pos_cnt,
    input  logic [NUM_LANES-1:0][COUNT_WIDTH-1:0]   step_cnt,
    input  logic [NUM_LANES-1:0][COUNT_WIDTH-1:0]   bad_cnt,
    input  logic [2*NUM_LANES-1:0][COUNT_WIDTH-1:0] tog_cnt,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output result_t                                 m_result
);

    logic [NUM_LANES-1:0][OUT_W-1:0]   pos_view;
    logic [NUM_LANES-1:0][OUT_W-1:0]   step_view;
    logic [NUM_LANES-1:0][OUT_W-1:0]   bad_view;
    logic [2*NUM_LANES-1:0][OUT_W-1:0] tog_view;

    result_t in_word;
    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    logic    s_fire;

    // position is sign-extended, other counts zero-extended; wider ones are truncated
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane_view
        if (COUNT_WIDTH >= OUT_W) begin : g_wide
            assign pos_view[i]  = pos_cnt[i][OUT_W-1:0];
            assign step_view[i] = step_cnt[i][OUT_W-1:0];
            assign bad_view[i]  = bad_cnt[i][OUT_W-1:0];
        end else begin : g_narrow
            assign pos_view[i]  = {{(OUT_W-COUNT_WIDTH){pos_cnt[i][COUNT_WIDTH-1]}},
                                   pos_cnt[i]};
            assign step_view[i] = OUT_W'(step_cnt[i]);
            assign bad_view[i]  = OUT_W'(bad_cnt[i]);
        end
    end

    for (genvar j = 0; j < 2*NUM_LANES; j++) begin : g_tog_view
        if (COUNT_WIDTH >= OUT_W) begin : g_wide
            assign tog_view[j] = tog_cnt[j][OUT_W-1:0];
        end else begin : g_narrow
            assign tog_view[j] = OUT_W'(tog_cnt[j]);
        end
    end

    always_comb begin
        in_word.position_a        = pos_view[0];
        in_word.position_b        = pos_view[1];
        in_word.steps_a           = step_view[0];
        in_word.steps_b           = step_view[1];
        in_word.invalid_a         = bad_view[0];
        in_word.invalid_b         = bad_view[1];
        in_word.toggles_a_phase_a = tog_view[0];
        in_word.toggles_a_phase_b = tog_view[1];
        in_word.toggles_b_phase_a = tog_view[2];
        in_word.toggles_b_phase_b = tog_view[3];
    end

    assign s_ready  = !skid_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = main_valid_reg;
    assign m_result = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= s_fire;
            end
        end else if (s_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || m_ready) begin
            main_reg <= skid_valid_reg ? skid_reg : in_word;
        end else if (s_fire) begin
            skid_reg <= in_word;
        end
    end

endmodule

[tb/sv/tb_dual_quadrature_decoder.sv]
// testbench for dual_quadrature_decoder: directed walk over every level transition, then random
// encoder motion under several invert settings, checked word by word against a local decoder
// depends on qdec_pkg and dual_quadrature_decoder
`timescale 1ns / 1ps

module tb_dual_quadrature_decoder;
    import qdec_pkg::*;

    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 390;
    localparam int DIRECTED_LEN = 22;

    typedef struct packed {
        logic       cmd;
        logic [1:0] lv_a;
        logic [1:0] lv_b;
        logic       zero_want;   // result is all zeros
    } sample_row_t;

    // first row is a no-change from reset, then a walk through all 16 level pairs on each
    // encoder, then restarts followed by a no-change and a double change on both encoders
    localparam sample_row_t DIRECTED [DIRECTED_LEN] = '{
        '{1'b0, 2'd0, 2'd0, 1'b1},
        '{1'b0, 2'd0, 2'd3, 1'b0},
        '{1'b0, 2'd1, 2'd3, 1'b0},
        '{1'b0, 2'd0, 2'd2, 1'b0},
        '{1'b0, 2'd2, 2'd2, 1'b0},
        '{1'b0, 2'd0, 2'd3, 1'b0},
        '{1'b0, 2'd3, 2'd1, 1'b0},
        '{1'b0, 2'd1, 2'd2, 1'b0},
        '{1'b0, 2'd1, 2'd1, 1'b0},
        '{1'b0, 2'd2, 2'd1, 1'b0},
        '{1'b0, 2'd1, 2'd3, 1'b0},
        '{1'b0, 2'd3, 2'd0, 1'b0},
        '{1'b0, 2'd2, 2'd2, 1'b0},
        '{1'b0, 2'd2, 2'd0, 1'b0},
        '{1'b0, 2'd3, 2'd1, 1'b0},
        '{1'b0, 2'd3, 2'd0, 1'b0},
        '{1'b0, 2'd0, 2'd0, 1'b0},
        '{1'b1, 2'd2, 2'd1, 1'b1},
        '{1'b0, 2'd2, 2'd1, 1'b1},
        '{1'b0, 2'd1, 2'd2, 1'b0},
        '{1'b1, 2'd3, 2'd3, 1'b1},
        '{1'b0, 2'd3, 2'd3, 1'b1}
    };

    // invert settings per random phase, {invert_a, invert_b}; last phase draws its own
    localparam logic [1:0] PHASE_INV [PHASES] = '{2'b10, 2'b11, 2'b00, 2'b01, 2'b00};

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_cmd = 1'b0;
    logic [LEVEL_W-1:0]      s_levels_a = '0;
    logic [LEVEL_W-1:0]      s_levels_b = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_position_a;
    logic signed [OUT_W-1:0] m_position_b;
    logic [OUT_W-1:0]        m_steps_a;
    logic [OUT_W-1:0]        m_steps_b;
    logic [OUT_W-1:0]        m_invalid_a;
    logic [OUT_W-1:0]        m_invalid_b;
    logic [OUT_W-1:0]        m_toggles_a_phase_a;
    logic [OUT_W-1:0]        m_toggles_a_phase_b;
    logic [OUT_W-1:0]        m_toggles_b_phase_a;
    logic [OUT_W-1:0]        m_toggles_b_phase_b;

    // local copy of the decoder state, index 0 is encoder A
    logic             invert [2];
    logic [1:0]       last_levels [2];
    logic [OUT_W-1:0] pos_cnt [2];
    logic [OUT_W-1:0] move_cnt [2];
    logic [OUT_W-1:0] bad_cnt [2];
    logic [OUT_W-1:0] flip_cnt [4];

    result_t pending_counts [$];
    int      mismatches = 0;
    int      words_seen = 0;
    bit      idle_off = 1'b0;
    logic [1:0] gen_a = '0;
    logic [1:0] gen_b = '0;

    dual_quadrature_decoder dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_levels_a          (s_levels_a),
        .s_levels_b          (s_levels_b),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_position_a        (m_position_a),
        .m_position_b        (m_position_b),
        .m_steps_a           (m_steps_a),
        .m_steps_b           (m_steps_b),
        .m_invalid_a         (m_invalid_a),
        .m_invalid_b         (m_invalid_b),
        .m_toggles_a_phase_a (m_toggles_a_phase_a),
        .m_toggles_a_phase_b (m_toggles_a_phase_b),
        .m_toggles_b_phase_a (m_toggles_b_phase_a),
        .m_toggles_b_phase_b (m_toggles_b_phase_b)
    );

    always #5 aclk = ~aclk;

    // levels as a position on the gray cycle 00 -> 01 -> 11 -> 10
    function automatic logic [1:0] gray_pos(input logic [1:0] lv);
        return {lv[1], lv[1] ^ lv[0]};
    endfunction

    function automatic logic [1:0] gray_levels(input logic [1:0] pos);
        return {pos[1], pos[1] ^ pos[0]};
    endfunction

    function automatic step_t lane_step(input logic [1:0] prev_lv, input logic [1:0] cur_lv);
        logic [1:0] d;
        d = gray_pos(cur_lv) - gray_pos(prev_lv);
        case (d)
            2'd1: return STEP_UP;
            2'd3: return STEP_DOWN;
            default: return STEP_NONE;
        endcase
    endfunction

    // advances the local state by one sample and returns the counts after it
    function automatic result_t decode_sample(input logic cmd, input logic [1:0] lv_a,
                                              input logic [1:0] lv_b);
        logic [1:0] cur [2];
        logic [1:0] diff;
        step_t      st;
        result_t    r;
        cur[0] = lv_a;
        cur[1] = lv_b;
        for (int k = 0; k < 2; k++) begin
            diff = last_levels[k] ^ cur[k];
            if (cmd) begin
                pos_cnt[k] = '0;
                move_cnt[k] = '0;
                bad_cnt[k] = '0;
                flip_cnt[2*k] = '0;
                flip_cnt[2*k+1] = '0;
            end else begin
                if (diff == 2'b11) begin
                    bad_cnt[k] = bad_cnt[k] + 32'd1;
                end else begin
                    st = lane_step(last_levels[k], cur[k]);
                    if (st != STEP_NONE) begin
                        if ((st == STEP_UP) != invert[k])
                            pos_cnt[k] = pos_cnt[k] + 32'd1;
                        else
                            pos_cnt[k] = pos_cnt[k] - 32'd1;
                        move_cnt[k] = move_cnt[k] + 32'd1;
                    end
                end
                if (diff[1])
                    flip_cnt[2*k] = flip_cnt[2*k] + 32'd1;
                if (diff[0])
                    flip_cnt[2*k+1] = flip_cnt[2*k+1] + 32'd1;
            end
            last_levels[k] = cur[k];
        end
        r.position_a        = pos_cnt[0];
        r.position_b        = pos_cnt[1];
        r.steps_a           = move_cnt[0];
        r.steps_b           = move_cnt[1];
        r.invalid_a         = bad_cnt[0];
        r.invalid_b         = bad_cnt[1];
        r.toggles_a_phase_a = flip_cnt[0];
        r.toggles_a_phase_b = flip_cnt[1];
        r.toggles_b_phase_a = flip_cnt[2];
        r.toggles_b_phase_b = flip_cnt[3];
        return r;
    endfunction

    // mostly legal motion, some holds, a few double changes and random jumps
    function automatic logic [1:0] next_levels(input logic [1:0] lv);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return gray_levels(gray_pos(lv) + ($urandom_range(0, 1) ? 2'd1 : 2'd3));
        else if (r < 85)
            return lv;
        else if (r < 93)
            return lv ^ 2'b11;
        else
            return 2'($urandom_range(0, 3));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch word %0d %s: got %h want %h", words_seen, what, got, want);
        mismatches++;
    endtask

    task automatic send_sample(input logic cmd, input logic [1:0] lv_a, input logic [1:0] lv_b,
                               input logic zero_want);
        int      gap;
        result_t want;
        gap = idle_off ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_levels_a <= lv_a;
        s_levels_b <= lv_b;
        do @(posedge aclk); while (!s_ready);
        want = decode_sample(cmd, lv_a, lv_b);
        if (zero_want)
            want = '0;
        pending_counts.push_back(want);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_INVERT_A)
            invert[0] = data[0];
        else if (idx == REG_INVERT_B)
            invert[1] = data[0];
    endtask

    task automatic drain_counts();
        while (pending_counts.size() != 0) @(posedge aclk);
    endtask

    // result side
    initial begin
        int      stall;
        result_t got;
        result_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = idle_off ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.position_a        = m_position_a;
            got.position_b        = m_position_b;
            got.steps_a           = m_steps_a;
            got.steps_b           = m_steps_b;
            got.invalid_a         = m_invalid_a;
            got.invalid_b         = m_invalid_b;
            got.toggles_a_phase_a = m_toggles_a_phase_a;
            got.toggles_a_phase_b = m_toggles_a_phase_b;
            got.toggles_b_phase_a = m_toggles_b_phase_a;
            got.toggles_b_phase_b = m_toggles_b_phase_b;
            if (pending_counts.size() == 0) begin
                report_mismatch("unexpected word, steps_a", got.steps_a, '0);
            end else begin
                want = pending_counts.pop_front();
                if (got.position_a !== want.position_a)
                    report_mismatch("position_a", got.position_a, want.position_a);
                if (got.position_b !== want.position_b)
                    report_mismatch("position_b", got.position_b, want.position_b);
                if (got.steps_a !== want.steps_a)
                    report_mismatch("steps_a", got.steps_a, want.steps_a);
                if (got.steps_b !== want.steps_b)
                    report_mismatch("steps_b", got.steps_b, want.steps_b);
                if (got.invalid_a !== want.invalid_a)
                    report_mismatch("invalid_a", got.invalid_a, want.invalid_a);
                if (got.invalid_b !== want.invalid_b)
                    report_mismatch("invalid_b", got.invalid_b, want.invalid_b);
                if (got.toggles_a_phase_a !== want.toggles_a_phase_a)
                    report_mismatch("toggles_a_phase_a", got.toggles_a_phase_a,
                                    want.toggles_a_phase_a);
                if (got.toggles_a_phase_b !== want.toggles_a_phase_b)
                    report_mismatch("toggles_a_phase_b", got.toggles_a_phase_b,
                                    want.toggles_a_phase_b);
                if (got.toggles_b_phase_a !== want.toggles_b_phase_a)
                    report_mismatch("toggles_b_phase_a", got.toggles_b_phase_a,
                                    want.toggles_b_phase_a);
                if (got.toggles_b_phase_b !== want.toggles_b_phase_b)
                    report_mismatch("toggles_b_phase_b", got.toggles_b_phase_b,
                                    want.toggles_b_phase_b);
            end
            words_seen++;
        end
    end

    // stimulus side
    initial begin
        logic       inv_a;
        logic       inv_b;
        logic       cmd;
        invert[0] = 1'b0;
        invert[1] = 1'b1;
        for (int k = 0; k < 2; k++) begin
            last_levels[k] = '0;
            pos_cnt[k] = '0;
            move_cnt[k] = '0;
            bad_cnt[k] = '0;
        end
        for (int k = 0; k < 4; k++)
            flip_cnt[k] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part runs on the reset invert settings
        for (int i = 0; i < DIRECTED_LEN; i++)
            send_sample(DIRECTED[i].cmd, DIRECTED[i].lv_a, DIRECTED[i].lv_b,
                        DIRECTED[i].zero_want);
        gen_a = DIRECTED[DIRECTED_LEN-1].lv_a;
        gen_b = DIRECTED[DIRECTED_LEN-1].lv_b;

        for (int p = 0; p < PHASES; p++) begin
            s_valid <= 1'b0;
            drain_counts();
            if (p == PHASES - 1) begin
                inv_a = 1'($urandom_range(0, 1));
                inv_b = 1'($urandom_range(0, 1));
            end else begin
                inv_a = PHASE_INV[p][1];
                inv_b = PHASE_INV[p][0];
            end
            // out-of-range index must be ignored, upper data bits must not matter
            write_reg(CFG_INDEX_W'($urandom_range(2, 255)), $urandom());
            write_reg(REG_INVERT_A, {31'($urandom() >> 1), inv_a});
            write_reg(REG_INVERT_B, {31'($urandom() >> 1), inv_b});
            cfg_valid <= 1'b0;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 48 == 0)
                    idle_off = ($urandom_range(0, 3) == 0);
                cmd = ($urandom_range(0, 49) == 0);
                if (cmd || $urandom_range(0, 39) == 0) begin
                    gen_a = 2'($urandom_range(0, 3));
                    gen_b = 2'($urandom_range(0, 3));
                end else begin
                    gen_a = next_levels(gen_a);
                    gen_b = next_levels(gen_b);
                end
                send_sample(cmd, gen_a, gen_b, 1'b0);
            end
        end

        s_valid <= 1'b0;
        drain_counts();
        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/qdec_pkg.sv
hw/rtl/qdec_lane.sv
hw/rtl/qdec_merge.sv
hw/rtl/dual_quadrature_decoder.sv
tb/sv/tb_dual_quadrature_decoder.sv
